// File: rtl/sfmh_pkg.sv
// ----------------------------------------------------------------------------
// sfmh_pkg
// Shared types and codes for the symbol frequency min-heap.
// ----------------------------------------------------------------------------
package sfmh_pkg;

    localparam int SYM_W  = 8;
    localparam int FREQ_W = 32;

    // operation codes on the func field
    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_BUILD   = 2'd1;
    localparam logic [1:0] FUNC_EXTRACT = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [FREQ_W-1:0] freq;
    } t_entry;

    // which slot holds the smallest key at one sift level
    typedef enum logic [1:0] {
        PICK_PARENT,
        PICK_LEFT,
        PICK_RIGHT
    } t_pick;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EX_LOAD,
        S_BLD_NEXT,
        S_BLD_LOAD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_RESP
    } t_state;

endpackage

// File: rtl/symbol_frequency_min_heap.sv
// ----------------------------------------------------------------------------
// symbol_frequency_min_heap
// Bounded binary min-heap of (symbol, frequency) entries keyed on frequency.
// ----------------------------------------------------------------------------
// One operation is taken per item and one result item is returned for it.
// An insert, like any failing or unused operation, is settled at dispatch
// and then shows its result. Extract hands out the root and sinks the last
// entry from the root by L levels, where L is at most log2(CAPACITY); each
// level costs one read of both children from the two read ports of the
// entry RAM and one pass through the shared compare unit. Build sinks each
// non-leaf slot the same way, from the last to the root. The block is not
// ready while an operation is in progress or its result waits to be taken.
module symbol_frequency_min_heap #(
    parameter int CAPACITY = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_func,
    input  logic [sfmh_pkg::SYM_W-1:0]  i_symbol,
    input  logic [sfmh_pkg::FREQ_W-1:0] i_frequency,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [sfmh_pkg::SYM_W-1:0]  o_out_symbol,
    output logic [sfmh_pkg::FREQ_W-1:0] o_out_frequency,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count
);
    import sfmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_func, n_func;
    t_entry        r_in, n_in;
    t_entry        r_cur, n_cur;
    logic [AW-1:0] r_at, n_at;
    logic [CW-1:0] r_i, n_i;
    logic          r_lok, n_lok;
    logic          r_rok, n_rok;
    logic [1:0]    r_status, n_status;
    t_entry        r_out, n_out;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    t_entry        rd_a;
    t_entry        rd_b;
    t_pick         pick;
    logic [XW-1:0] left_idx;
    logic [XW-1:0] right_idx;
    logic          in_acc;
    logic          out_acc;

    assign in_acc    = i_valid && o_ready;
    assign out_acc   = o_valid && i_ready;
    assign left_idx  = {1'b0, r_at, 1'b1};
    assign right_idx = left_idx + XW'(1);

    sfmh_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    sfmh_cmp u_cmp (
        .i_parent_freq (r_cur.freq),
        .i_left_freq   (rd_a.freq),
        .i_right_freq  (rd_b.freq),
        .i_left_ok     (r_lok),
        .i_right_ok    (r_rok),
        .o_pick        (pick)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_func == FUNC_BUILD && r_count >= CW'(2)) begin
                    n_state = S_BLD_NEXT;
                end else if (r_func == FUNC_EXTRACT && r_count != '0) begin
                    n_state = S_EX_LOAD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_EX_LOAD:  n_state = S_SIFT_RD;
            S_BLD_NEXT: n_state = S_BLD_LOAD;
            S_BLD_LOAD: n_state = S_SIFT_RD;
            S_SIFT_RD:  n_state = S_SIFT_CMP;
            S_SIFT_CMP: begin
                if (pick != PICK_PARENT) begin
                    n_state = S_SIFT_RD;
                end else if (r_func == FUNC_BUILD && r_i != '0) begin
                    n_state = S_BLD_NEXT;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count   = r_count;
        n_func    = r_func;
        n_in      = r_in;
        n_cur     = r_cur;
        n_at      = r_at;
        n_i       = r_i;
        n_lok     = r_lok;
        n_rok     = r_rok;
        n_status  = r_status;
        n_out     = r_out;
        wr_en     = 1'b0;
        wr_addr   = r_at;
        wr_data   = r_cur;
        rd_addr_a = r_at;
        rd_addr_b = r_at;
        case (r_state)
            S_IDLE: begin
                // latch the item and clear the result
                n_func   = i_func;
                n_in     = '{sym: i_symbol, freq: i_frequency};
                n_status = ST_OK;
                n_out    = '0;
            end
            S_DISPATCH: begin
                case (r_func)
                    FUNC_INSERT: begin
                        if (r_count >= CAP_C) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            wr_data = r_in;
                            n_count = r_count + CW'(1);
                        end
                    end
                    FUNC_BUILD: begin
                        // last non-leaf slot plus one
                        n_i = r_count >> 1;
                    end
                    FUNC_EXTRACT: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end
                        rd_addr_a = '0;
                        rd_addr_b = AW'(r_count - CW'(1));
                    end
                    default: begin
                    end
                endcase
            end
            S_EX_LOAD: begin
                // hand out the root, sink the last entry from the root
                n_out   = rd_a;
                n_cur   = rd_b;
                n_count = r_count - CW'(1);
                n_at    = '0;
            end
            S_BLD_NEXT: begin
                n_i       = r_i - CW'(1);
                n_at      = AW'(r_i - CW'(1));
                rd_addr_a = AW'(r_i - CW'(1));
            end
            S_BLD_LOAD: begin
                n_cur = rd_a;
            end
            S_SIFT_RD: begin
                // fetch both children and flag those inside the heap
                rd_addr_a = left_idx[AW-1:0];
                rd_addr_b = right_idx[AW-1:0];
                n_lok     = left_idx < XW'(r_count);
                n_rok     = right_idx < XW'(r_count);
            end
            S_SIFT_CMP: begin
                wr_en = 1'b1;
                case (pick)
                    PICK_LEFT: begin
                        wr_data = rd_a;
                        n_at    = left_idx[AW-1:0];
                    end
                    PICK_RIGHT: begin
                        wr_data = rd_b;
                        n_at    = right_idx[AW-1:0];
                    end
                    default: begin
                        wr_data = r_cur;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_in     <= n_in;
        r_cur    <= n_cur;
        r_at     <= n_at;
        r_i      <= n_i;
        r_lok    <= n_lok;
        r_rok    <= n_rok;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_RESP);
    assign o_status        = r_status;
    assign o_out_symbol    = r_out.sym;
    assign o_out_frequency = r_out.freq;
    assign o_entry_count   = r_count;

    // never take an item while a result is shown
    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and valid high together");

    // held count stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("held count above capacity");

    // a shown result holds its count until taken
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_entry_count)))
        else $error("result count changed while stalled");

    // an insert into a heap with room grows the count by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == FUNC_INSERT && r_count < CAP_C)
        |=> ##1 (r_count == $past(r_count, 2) + CW'(1)))
        else $error("insert did not grow the count");

    // a result leaves the block idle
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> o_ready)
        else $error("not idle after result taken");

endmodule

// File: rtl/sfmh_ram.sv
// ----------------------------------------------------------------------------
// sfmh_ram
// Entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sfmh_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  sfmh_pkg::t_entry i_wr_data,
    input  logic [AW-1:0]   i_rd_addr_a,
    input  logic [AW-1:0]   i_rd_addr_b,
    output sfmh_pkg::t_entry o_rd_data_a,
    output sfmh_pkg::t_entry o_rd_data_b
);
    import sfmh_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // register both reads
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// File: rtl/sfmh_cmp.sv
// ----------------------------------------------------------------------------
// sfmh_cmp
// Shared compare unit: picks the smallest key among a parent and its children.
// ----------------------------------------------------------------------------
module sfmh_cmp (
    input  logic [sfmh_pkg::FREQ_W-1:0] i_parent_freq,
    input  logic [sfmh_pkg::FREQ_W-1:0] i_left_freq,
    input  logic [sfmh_pkg::FREQ_W-1:0] i_right_freq,
    input  logic                        i_left_ok,
    input  logic                        i_right_ok,
    output sfmh_pkg::t_pick             o_pick
);
    import sfmh_pkg::*;

    logic              take_left;
    logic [FREQ_W-1:0] best_freq;

    // left first, strict less so the parent wins ties
    always_comb begin
        take_left = i_left_ok && (i_left_freq < i_parent_freq);
        best_freq = take_left ? i_left_freq : i_parent_freq;
        if (i_right_ok && (i_right_freq < best_freq)) begin
            o_pick = PICK_RIGHT;
        end else if (take_left) begin
            o_pick = PICK_LEFT;
        end else begin
            o_pick = PICK_PARENT;
        end
    end

endmodule
